// ===== rtl/dos_pkg.sv =====
// ----------------------------------------------------------------------------
// dos_pkg
// Shared types and constants for the DER OCTET STRING decoder.
// ----------------------------------------------------------------------------
package dos_pkg;

  localparam int MAX_LEN_OCTETS = 4;                  // long-form length octets, 1..8
  localparam int BYTE_BITS      = 8;
  localparam int ACC_W          = BYTE_BITS * MAX_LEN_OCTETS;
  localparam int CMP_W          = (ACC_W > 32) ? ACC_W : 32;
  localparam int OCT_W          = $clog2(MAX_LEN_OCTETS + 1);
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);
  localparam int Q_CW           = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]  TAG_OCTET_STRING = 8'h04;
  localparam logic [31:0] MIN_HEADER       = 32'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TOO_SMALL = 2'd2,
    ST_ARGS_BAD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_LENOCT,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [31:0] buffer_length;
    logic [31:0] out_capacity;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        last;
    logic [1:0]  status;
    logic [31:0] content_length;
  } result_t;

  // command word from the header parser to the output side
  typedef struct packed {
    logic        is_data;
    logic [7:0]  data;
    logic        last;
    status_t     status;
    logic [31:0] clen;
  } cmd_t;

endpackage

// ===== rtl/dos_front.sv =====
// ----------------------------------------------------------------------------
// dos_front
// Header parser: tag, length form, length octets, bound checks, content count.
// ----------------------------------------------------------------------------
module dos_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  dos_pkg::item_t item,
  output logic           cmd_push,
  output dos_pkg::cmd_t  cmd
);
  import dos_pkg::*;

  phase_t            phase, phase_next;
  logic [31:0]       room;          // buffer bytes left for content after the header
  logic [31:0]       capacity;
  logic [OCT_W-1:0]  octets_left;
  logic [ACC_W-1:0]  accum;
  logic [31:0]       content_left;

  logic [7:0]        b;
  logic [6:0]        n_oct;
  logic              n_bad;
  logic              hdr_end;
  logic [ACC_W-1:0]  acc_new;
  logic              len_gt_room, len_gt_cap, len_zero;

  assign b     = item.data_byte;
  assign n_oct = b[6:0];
  assign n_bad = (n_oct == 7'd0) || (n_oct > 7'(MAX_LEN_OCTETS))
                 || (32'(n_oct) > room);

  // length value at the end of the header, and its checks
  always_comb begin
    hdr_end = 1'b0;
    acc_new = (accum << BYTE_BITS) | ACC_W'(b);
    if (phase == PH_LEN && !b[7]) begin
      hdr_end = 1'b1;
      acc_new = ACC_W'(b);
    end else if (phase == PH_LENOCT && octets_left == OCT_W'(1)) begin
      hdr_end = 1'b1;
    end
  end

  assign len_gt_room = CMP_W'(acc_new) > CMP_W'(room);
  assign len_gt_cap  = CMP_W'(acc_new) > CMP_W'(capacity);
  assign len_zero    = acc_new == '0;

  // next state
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (item.first) begin
        if (item.buffer_length < MIN_HEADER || b != TAG_OCTET_STRING) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_LEN;
        end
      end else begin
        case (phase)
          PH_LEN: begin
            if (hdr_end) begin
              phase_next = (len_gt_room || len_gt_cap || len_zero) ? PH_DONE : PH_DATA;
            end else if (n_bad) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_LENOCT;
            end
          end
          PH_LENOCT: begin
            if (hdr_end) begin
              phase_next = (len_gt_room || len_gt_cap || len_zero) ? PH_DONE : PH_DATA;
            end
          end
          PH_DATA: begin
            if (content_left == 32'd1) begin
              phase_next = PH_DONE;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // command outputs
  always_comb begin
    cmd_push     = 1'b0;
    cmd.is_data  = 1'b0;
    cmd.data     = b;
    cmd.last     = 1'b1;
    cmd.status   = ST_OK;
    cmd.clen     = 32'd0;
    if (accept) begin
      if (item.first) begin
        if (item.buffer_length < MIN_HEADER) begin
          cmd_push   = 1'b1;
          cmd.status = ST_ARGS_BAD;
        end else if (b != TAG_OCTET_STRING) begin
          cmd_push   = 1'b1;
          cmd.status = ST_INVALID;
        end
      end else begin
        case (phase)
          PH_LEN, PH_LENOCT: begin
            if (hdr_end) begin
              if (len_gt_room) begin
                cmd_push   = 1'b1;
                cmd.status = ST_INVALID;
              end else if (len_gt_cap) begin
                cmd_push   = 1'b1;
                cmd.status = ST_TOO_SMALL;
                cmd.clen   = acc_new[31:0];
              end else if (len_zero) begin
                cmd_push   = 1'b1;
              end
            end else if (phase == PH_LEN && n_bad) begin
              cmd_push   = 1'b1;
              cmd.status = ST_INVALID;
            end
          end
          PH_DATA: begin
            cmd_push    = 1'b1;
            cmd.is_data = 1'b1;
            cmd.last    = content_left == 32'd1;
            cmd.clen    = accum[31:0];
          end
          default: cmd_push = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (item.first) begin
        room        <= item.buffer_length - MIN_HEADER;
        capacity    <= item.out_capacity;
        octets_left <= '0;
        accum       <= '0;
        content_left <= 32'd0;
      end else begin
        case (phase)
          PH_LEN: begin
            if (hdr_end) begin
              accum        <= acc_new;
              content_left <= acc_new[31:0];
            end else begin
              room        <= room - 32'(n_oct);
              octets_left <= OCT_W'(n_oct);
              accum       <= '0;
            end
          end
          PH_LENOCT: begin
            accum       <= acc_new;
            octets_left <= octets_left - OCT_W'(1);
            if (hdr_end) begin
              content_left <= acc_new[31:0];
            end
          end
          PH_DATA: begin
            content_left <= content_left - 32'd1;
          end
          default: content_left <= content_left;
        endcase
      end
    end
  end

endmodule

// ===== rtl/dos_fifo.sv =====
// ----------------------------------------------------------------------------
// dos_fifo
// Short command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module dos_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dos_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          avail,
  output dos_pkg::cmd_t rdata
);
  import dos_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_CW-1:0] count;

  assign full  = count == Q_CW'(Q_DEPTH);
  assign avail = count != '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + Q_AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + Q_AW'(1);
      end
      count <= count + Q_CW'(wr) - Q_CW'(rd);
    end
  end

endmodule

// ===== rtl/dos_back.sv =====
// ----------------------------------------------------------------------------
// dos_back
// Output stage: turns commands into result words and holds one for the sink.
// ----------------------------------------------------------------------------
module dos_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_avail,
  input  dos_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output dos_pkg::result_t result
);
  import dos_pkg::*;

  logic    held;
  result_t word;

  assign empty   = !held;
  assign result  = word;
  assign cmd_pop = cmd_avail && (!held || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_pop) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      word.payload_byte   <= cmd.is_data ? cmd.data : 8'd0;
      word.has_payload    <= cmd.is_data;
      word.last           <= cmd.last;
      word.status         <= cmd.status;
      word.content_length <= cmd.clen;
    end
  end

endmodule

// ===== rtl/der_octet_string_decoder_core.sv =====
// ----------------------------------------------------------------------------
// der_octet_string_decoder_core
// DER OCTET STRING decoder: one buffer byte in per word, content bytes or one
// status word out.
// ----------------------------------------------------------------------------
//
//  channel   handshake         payload   dir
//  -------   ---------------   -------   ---
//  input     push / full       item      in   one DER byte, first marks a tag
//  result    pop / empty       result    out  content byte or status, last mark
//
//  One input word per cycle while the command queue has room; the parser
//  handles each byte on acceptance and decides at most one result word for it.
//  A result is written into the command queue at the accepting edge and
//  into the output register once that register is free or being popped.
//  rst is synchronous and clears parser phase, queue and output valid.
//  full follows the two-entry command queue only, so input is taken while a
//  finished result still waits in the output register.
//
module der_octet_string_decoder_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  dos_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output dos_pkg::result_t result
);
  import dos_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic q_full;
  logic q_avail;
  logic q_pop;
  cmd_t q_out;

  // bytes are taken whenever the command queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: tag / length parsing and bound checks
  dos_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // decoupling queue
  dos_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .full  (q_full),
    .rd    (q_pop),
    .avail (q_avail),
    .rdata (q_out)
  );

  // back: result formatting and output register
  dos_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (q_avail),
    .cmd       (q_out),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // a command is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command queue overflow");

  // a status-only word always closes its buffer
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.has_payload) |-> result.last)
    else $error("status word without last");

  // content bytes only go out with ok status
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.has_payload) |-> (result.status == ST_OK))
    else $error("content byte with error status");

  // output register is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule
